// ===== rtl/smi_pkg.sv =====
// Shared constants, command/status structs and permutation tables for the
// small matrix inverse block. No dependencies.
`timescale 1ns / 1ps

package smi_pkg;

    localparam int ELEMENT_BITS = 8;
    localparam int MAX_SIZE     = 4;
    localparam int CELLS        = MAX_SIZE * MAX_SIZE;
    localparam int ADDR_W       = $clog2(CELLS);
    localparam int IDX_W        = $clog2(MAX_SIZE);
    localparam int SIZE_W       = 3;
    localparam int CNT_W        = 5;
    localparam int ADJ_W        = 25;
    localparam int DET_W        = 34;
    localparam int QUO_W        = 41;
    localparam int FRAC_BITS    = 16;
    localparam int DIV_CNT_W    = $clog2(QUO_W + 1);

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [ADDR_W-1:0] rd_addr;
        logic              prod_init;
        logic              prod_mul;
        logic              term_add;
        logic              term_neg;
        logic              cof_clr;
        logic              det_clr;
        logic              det_mac;
        logic              div_start;
        logic              capture;
        logic              cap_zero;
    } smi_cmd_t;

    typedef struct packed {
        logic det_zero;
        logic div_done;
    } smi_stat_t;

    // Number of permutation terms in the determinant of an m x m minor.
    function automatic logic [2:0] term_count(input logic [1:0] m);
        logic [2:0] res;
        case (m)
            2'd1:    res = 3'd1;
            2'd2:    res = 3'd2;
            2'd3:    res = 3'd6;
            default: res = 3'd1;
        endcase
        return res;
    endfunction

    // Minor column picked at minor row p by permutation term t.
    function automatic logic [1:0] perm_col(input logic [1:0] m, input logic [2:0] t,
                                            input logic [1:0] p);
        logic [1:0] res;
        res = 2'd0;
        case (m)
            2'd2:    res = (t == 3'd0) ? p : 2'(2'd1 - p);
            2'd3:
            begin
                case (t)
                    3'd0:    res = p;
                    3'd1:    res = (p == 2'd0) ? 2'd0 : ((p == 2'd1) ? 2'd2 : 2'd1);
                    3'd2:    res = (p == 2'd0) ? 2'd1 : ((p == 2'd1) ? 2'd0 : 2'd2);
                    3'd3:    res = (p == 2'd0) ? 2'd1 : ((p == 2'd1) ? 2'd2 : 2'd0);
                    3'd4:    res = (p == 2'd0) ? 2'd2 : ((p == 2'd1) ? 2'd0 : 2'd1);
                    3'd5:    res = (p == 2'd0) ? 2'd2 : ((p == 2'd1) ? 2'd1 : 2'd0);
                    default: res = 2'd0;
                endcase
            end
            default: res = 2'd0;
        endcase
        return res;
    endfunction

    // Odd permutations carry a minus sign.
    function automatic logic perm_neg(input logic [1:0] m, input logic [2:0] t);
        logic res;
        case (m)
            2'd2:    res = (t == 3'd1);
            2'd3:    res = (t == 3'd1) || (t == 3'd2) || (t == 3'd5);
            default: res = 1'b0;
        endcase
        return res;
    endfunction

endpackage

// ===== rtl/small_matrix_inverse_top.sv =====
// Small matrix inverse by the adjugate method: top level.
// The determinant needs n cofactors along the first row, and each inverse word
// needs one more cofactor and a division by the determinant.
// Throughput is one matrix at a time; busy stays high from the final entry to the
// last result. The receiver cannot stall: each result word shows for one cycle.
// Reset (rst_n, asynchronous, active low) sets the size to 4 and empties the load.
// Depends on smi_pkg, smi_ctrl, smi_dp and smi_div.
`timescale 1ns / 1ps

module small_matrix_inverse_top (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // Entry words, row-major, taken when start is high and busy is low.
    input  logic                                    start,
    output logic                                    busy,
    input  logic signed [smi_pkg::ELEMENT_BITS-1:0] matrix_entry,
    // Size register write channel; writes are taken only while idle and
    // discard any partially loaded matrix.
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [smi_pkg::SIZE_W-1:0]              cfg_data,
    // Result words, each valid for the single cycle that result_valid is high.
    output logic                                    result_valid,
    output logic [smi_pkg::IDX_W-1:0]               row_index,
    output logic [smi_pkg::IDX_W-1:0]               col_index,
    output logic signed [smi_pkg::ADJ_W-1:0]        adjugate_entry,
    output logic signed [smi_pkg::QUO_W-1:0]        inverse_q16,
    output logic signed [smi_pkg::DET_W-1:0]        determinant,
    output logic                                    singular,
    output logic                                    last_result
);

    // The controller sequences all work; the datapath only follows commands.
    smi_pkg::smi_cmd_t  cmd;
    smi_pkg::smi_stat_t stat;

    smi_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .stat         (stat),
        .cmd          (cmd),
        .result_valid (result_valid),
        .row_index    (row_index),
        .col_index    (col_index),
        .singular     (singular),
        .last_result  (last_result)
    );

    // The datapath holds the entries, accumulates cofactor products, builds the
    // determinant along the first row, and divides each adjugate entry by it.
    smi_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .matrix_entry   (matrix_entry),
        .stat           (stat),
        .adjugate_entry (adjugate_entry),
        .inverse_q16    (inverse_q16),
        .determinant    (determinant)
    );

endmodule

// ===== rtl/smi_div.sv =====
// Restoring signed divider, one quotient bit per cycle.
// Depends on smi_pkg for the operand widths.
`timescale 1ns / 1ps

module smi_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [smi_pkg::QUO_W-1:0]  num,
    input  logic signed [smi_pkg::DET_W-1:0]  den,
    output logic                              done,
    output logic signed [smi_pkg::QUO_W-1:0]  quo
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [smi_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [smi_pkg::QUO_W-1:0]     quo_reg;
    logic [smi_pkg::DET_W-1:0]     rem_reg;
    logic [smi_pkg::DET_W-1:0]     den_reg;
    logic                          neg_reg;

    logic [smi_pkg::DET_W:0]       trial;
    logic                          fits;

    assign trial = {rem_reg, quo_reg[smi_pkg::QUO_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= smi_pkg::DIV_CNT_W'(smi_pkg::QUO_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == smi_pkg::DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num[smi_pkg::QUO_W-1] ? smi_pkg::QUO_W'(-num) : num;
            den_reg <= den[smi_pkg::DET_W-1] ? smi_pkg::DET_W'(-den) : den;
            rem_reg <= '0;
            neg_reg <= num[smi_pkg::QUO_W-1] ^ den[smi_pkg::DET_W-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? smi_pkg::DET_W'(trial - {1'b0, den_reg})
                            : trial[smi_pkg::DET_W-1:0];
            quo_reg <= {quo_reg[smi_pkg::QUO_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quo  = neg_reg ? smi_pkg::QUO_W'(-quo_reg) : quo_reg;

endmodule

// ===== rtl/smi_dp.sv =====
// Datapath: entry memory, product and cofactor accumulators, determinant
// and result registers. Depends on smi_pkg and smi_div.
`timescale 1ns / 1ps

module smi_dp (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  smi_pkg::smi_cmd_t                      cmd,
    input  logic signed [smi_pkg::ELEMENT_BITS-1:0] matrix_entry,
    output smi_pkg::smi_stat_t                     stat,
    output logic signed [smi_pkg::ADJ_W-1:0]       adjugate_entry,
    output logic signed [smi_pkg::QUO_W-1:0]       inverse_q16,
    output logic signed [smi_pkg::DET_W-1:0]       determinant
);

    logic signed [smi_pkg::ELEMENT_BITS-1:0] entry_mem_reg [smi_pkg::CELLS];
    logic signed [smi_pkg::ELEMENT_BITS-1:0] rdata_reg;
    logic signed [smi_pkg::ADJ_W-1:0]        prod_reg;
    logic signed [smi_pkg::ADJ_W-1:0]        cof_reg;
    logic signed [smi_pkg::DET_W-1:0]        det_reg;
    logic signed [smi_pkg::ADJ_W-1:0]        adj_out_reg;
    logic signed [smi_pkg::QUO_W-1:0]        quo_out_reg;
    logic signed [smi_pkg::DET_W-1:0]        det_out_reg;

    logic signed [smi_pkg::ADJ_W+smi_pkg::ELEMENT_BITS-1:0] prod_full;
    logic signed [smi_pkg::ADJ_W+smi_pkg::ELEMENT_BITS-1:0] mac_full;
    logic signed [smi_pkg::QUO_W-1:0]        num_ext;
    logic signed [smi_pkg::QUO_W-1:0]        div_quo;
    logic                                    div_done;

    assign prod_full = prod_reg * rdata_reg;
    assign mac_full  = cof_reg * rdata_reg;
    assign num_ext   = smi_pkg::QUO_W'(cof_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            entry_mem_reg[cmd.wr_addr] <= matrix_entry;
        end
        rdata_reg <= entry_mem_reg[cmd.rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.prod_init)
        begin
            prod_reg <= smi_pkg::ADJ_W'(1);
        end
        else if (cmd.prod_mul)
        begin
            prod_reg <= smi_pkg::ADJ_W'(prod_full);
        end

        if (cmd.cof_clr)
        begin
            cof_reg <= '0;
        end
        else if (cmd.term_add)
        begin
            cof_reg <= cmd.term_neg ? cof_reg - prod_reg : cof_reg + prod_reg;
        end

        if (cmd.det_clr)
        begin
            det_reg <= '0;
        end
        else if (cmd.det_mac)
        begin
            det_reg <= det_reg + smi_pkg::DET_W'(mac_full);
        end

        if (cmd.capture)
        begin
            adj_out_reg <= cmd.cap_zero ? '0 : cof_reg;
            quo_out_reg <= cmd.cap_zero ? '0 : div_quo;
            det_out_reg <= cmd.cap_zero ? '0 : det_reg;
        end
    end

    smi_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (num_ext <<< smi_pkg::FRAC_BITS),
        .den   (det_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign stat.det_zero  = (det_reg == '0);
    assign stat.div_done  = div_done;
    assign adjugate_entry = adj_out_reg;
    assign inverse_q16    = quo_out_reg;
    assign determinant    = det_out_reg;

endmodule

// ===== rtl/smi_ctrl.sv =====
// Controller: loading, size register, cofactor sequencing and result strobes.
// Depends on smi_pkg; drives the datapath only through smi_cmd_t.
`timescale 1ns / 1ps

module smi_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [smi_pkg::SIZE_W-1:0]   cfg_data,
    input  smi_pkg::smi_stat_t           stat,
    output smi_pkg::smi_cmd_t            cmd,
    output logic                         result_valid,
    output logic [smi_pkg::IDX_W-1:0]    row_index,
    output logic [smi_pkg::IDX_W-1:0]    col_index,
    output logic                         singular,
    output logic                         last_result
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_COF_INIT, ST_TERM_INIT, ST_RD, ST_MUL, ST_TERM_ADD,
        ST_COF_DONE, ST_DET_MAC, ST_CHECK, ST_DIV_WAIT
    } state_t;

    state_t                      state_reg, state_next;
    logic [smi_pkg::SIZE_W-1:0]  size_reg, size_next;
    logic [smi_pkg::CNT_W-1:0]   load_cnt_reg, load_cnt_next;
    logic                        phase_det_reg, phase_det_next;
    logic [2:0]                  t_reg, t_next;
    logic [1:0]                  p_reg, p_next;
    logic [smi_pkg::IDX_W-1:0]   k_reg, k_next;
    logic [smi_pkg::IDX_W-1:0]   row_reg, row_next;
    logic [smi_pkg::IDX_W-1:0]   col_reg, col_next;
    logic                        strobe_reg, strobe_next;
    logic [smi_pkg::IDX_W-1:0]   out_row_reg, out_row_next;
    logic [smi_pkg::IDX_W-1:0]   out_col_reg, out_col_next;
    logic                        sing_reg, sing_next;
    logic                        last_reg, last_next;

    logic [smi_pkg::SIZE_W-1:0]  n_eff;
    logic [smi_pkg::CNT_W-1:0]   total;
    logic [1:0]                  m;
    logic [smi_pkg::IDX_W-1:0]   n_last;
    logic [smi_pkg::IDX_W-1:0]   skip_r, skip_c;
    logic [1:0]                  mcol;
    logic [smi_pkg::IDX_W-1:0]   act_r, act_c;
    logic                        accept, cfg_wr, last_entry, last_cell;

    always_comb
    begin
        if (size_reg < smi_pkg::SIZE_W'(2))
            n_eff = smi_pkg::SIZE_W'(2);
        else if (size_reg > smi_pkg::SIZE_W'(smi_pkg::MAX_SIZE))
            n_eff = smi_pkg::SIZE_W'(smi_pkg::MAX_SIZE);
        else
            n_eff = size_reg;
    end

    assign total      = smi_pkg::CNT_W'(n_eff) * smi_pkg::CNT_W'(n_eff);
    assign m          = 2'(n_eff - 1'b1);
    assign n_last     = smi_pkg::IDX_W'(n_eff - 1'b1);
    assign busy       = (state_reg != ST_IDLE);
    assign cfg_ready  = !busy;
    assign accept     = start && !busy;
    assign cfg_wr     = cfg_valid && cfg_ready;
    assign last_entry = (load_cnt_reg == total - 1'b1);
    assign last_cell  = (row_reg == n_last) && (col_reg == n_last);

    // Cofactor (i, j) of the adjugate at (r, c) deletes row c and column r.
    assign skip_r = phase_det_reg ? '0 : col_reg;
    assign skip_c = phase_det_reg ? k_reg : row_reg;
    assign mcol   = smi_pkg::perm_col(m, t_reg, p_reg);
    assign act_r  = smi_pkg::IDX_W'(p_reg) + smi_pkg::IDX_W'(p_reg >= skip_r);
    assign act_c  = smi_pkg::IDX_W'(mcol) + smi_pkg::IDX_W'(mcol >= skip_c);

    always_comb
    begin
        state_next     = state_reg;
        size_next      = size_reg;
        load_cnt_next  = load_cnt_reg;
        phase_det_next = phase_det_reg;
        t_next         = t_reg;
        p_next         = p_reg;
        k_next         = k_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        strobe_next    = 1'b0;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        sing_next      = sing_reg;
        last_next      = last_reg;
        cmd            = '0;
        cmd.wr_addr    = load_cnt_reg[smi_pkg::ADDR_W-1:0];
        cmd.rd_addr    = smi_pkg::ADDR_W'(smi_pkg::ADDR_W'(act_r) * smi_pkg::ADDR_W'(n_eff)
                                          + smi_pkg::ADDR_W'(act_c));
        cmd.term_neg   = smi_pkg::perm_neg(m, t_reg) ^ skip_r[0] ^ skip_c[0];

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.wr_en = 1'b1;
                    if (last_entry)
                    begin
                        load_cnt_next  = '0;
                        phase_det_next = 1'b1;
                        k_next         = '0;
                        cmd.det_clr    = 1'b1;
                        state_next     = ST_COF_INIT;
                    end
                    else
                    begin
                        load_cnt_next = load_cnt_reg + 1'b1;
                    end
                end
                if (cfg_wr)
                begin
                    size_next     = cfg_data;
                    load_cnt_next = '0;
                end
            end
            ST_COF_INIT:
            begin
                cmd.cof_clr = 1'b1;
                t_next      = '0;
                state_next  = ST_TERM_INIT;
            end
            ST_TERM_INIT:
            begin
                cmd.prod_init = 1'b1;
                p_next        = '0;
                state_next    = ST_RD;
            end
            ST_RD:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.prod_mul = 1'b1;
                if (p_reg == m - 1'b1)
                begin
                    state_next = ST_TERM_ADD;
                end
                else
                begin
                    p_next     = p_reg + 1'b1;
                    state_next = ST_RD;
                end
            end
            ST_TERM_ADD:
            begin
                cmd.term_add = 1'b1;
                if (t_reg == smi_pkg::term_count(m) - 1'b1)
                begin
                    state_next = ST_COF_DONE;
                end
                else
                begin
                    t_next     = t_reg + 1'b1;
                    state_next = ST_TERM_INIT;
                end
            end
            ST_COF_DONE:
            begin
                if (phase_det_reg)
                begin
                    cmd.rd_addr = smi_pkg::ADDR_W'(k_reg);
                    state_next  = ST_DET_MAC;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV_WAIT;
                end
            end
            ST_DET_MAC:
            begin
                cmd.det_mac = 1'b1;
                if (k_reg == n_last)
                begin
                    state_next = ST_CHECK;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_COF_INIT;
                end
            end
            ST_CHECK:
            begin
                if (stat.det_zero)
                begin
                    cmd.capture  = 1'b1;
                    cmd.cap_zero = 1'b1;
                    strobe_next  = 1'b1;
                    out_row_next = '0;
                    out_col_next = '0;
                    sing_next    = 1'b1;
                    last_next    = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    phase_det_next = 1'b0;
                    row_next       = '0;
                    col_next       = '0;
                    state_next     = ST_COF_INIT;
                end
            end
            ST_DIV_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.capture  = 1'b1;
                    strobe_next  = 1'b1;
                    out_row_next = row_reg;
                    out_col_next = col_reg;
                    sing_next    = 1'b0;
                    last_next    = last_cell;
                    if (last_cell)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        if (col_reg == n_last)
                        begin
                            col_next = '0;
                            row_next = row_reg + 1'b1;
                        end
                        else
                        begin
                            col_next = col_reg + 1'b1;
                        end
                        state_next = ST_COF_INIT;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            size_reg      <= smi_pkg::SIZE_W'(smi_pkg::MAX_SIZE);
            load_cnt_reg  <= '0;
            phase_det_reg <= 1'b0;
            t_reg         <= '0;
            p_reg         <= '0;
            k_reg         <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            strobe_reg    <= 1'b0;
            out_row_reg   <= '0;
            out_col_reg   <= '0;
            sing_reg      <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            size_reg      <= size_next;
            load_cnt_reg  <= load_cnt_next;
            phase_det_reg <= phase_det_next;
            t_reg         <= t_next;
            p_reg         <= p_next;
            k_reg         <= k_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            strobe_reg    <= strobe_next;
            out_row_reg   <= out_row_next;
            out_col_reg   <= out_col_next;
            sing_reg      <= sing_next;
            last_reg      <= last_next;
        end
    end

    assign result_valid = strobe_reg;
    assign row_index    = out_row_reg;
    assign col_index    = out_col_reg;
    assign singular     = sing_reg;
    assign last_result  = last_reg;

    a_sing_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && sing_reg |-> last_reg)
        else $error("singular result not marked last");

    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg |=> !strobe_reg)
        else $error("results on consecutive cycles");

    a_last_entry_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_entry && !cfg_wr |=> busy)
        else $error("final entry did not start a computation");

    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        stat.div_done |-> state_reg == ST_DIV_WAIT)
        else $error("divider finished outside its wait state");

endmodule
